### sv/ackwa_pkg.sv
// Package for the Ackermann wheel angle pipeline.
// Holds the CORDIC arctangent table, register indexes and the shared types.
// No dependencies.
package ackwa_pkg;

  localparam int MaxStages = 24;

  // atan(2^-i) in radians scaled by 2^24
  localparam logic [23:0] ATAN_Q24 [MaxStages] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  localparam logic [13:0] HALF_PI_Q13 = 14'd12868;
  localparam logic [16:0] DEG_TO_RAD_Q16 = 17'd73204;
  localparam logic [15:0] CORDIC_ONE = 16'd16; // 2^20 is built as ONE << 16

  typedef enum logic [1:0] {
    REG_WHEELBASE   = 2'd0,
    REG_TRACK_WIDTH = 2'd1,
    REG_STEER_LIMIT = 2'd2,
    REG_THROT_LIMIT = 2'd3
  } reg_idx_e;

  // special cases of one wheel
  typedef struct packed {
    logic zero_num;
    logic zero_den;
    logic num_pos;
  } flg_t;

  // data riding beside the arithmetic
  typedef struct packed {
    logic signed [14:0] ang;
    logic signed [15:0] thr;
    logic               link;
    flg_t               fr;
    flg_t               fl;
  } side_t;

endpackage

### sv/ackermann_wheel_angles.sv
// Ackermann front wheel angle pipeline: top level.
// Depends on ackwa_pkg.
// ---------------------------------------------------------------------------
// Usage:
//  - Slave stream: s_axis_tdata = {throttle_cmd, steer_cmd}, tuser = link_up.
//    A request is taken when tvalid and tready are both high.
//  - Master stream: one result per request, tdata packs right, left and
//    center wheel angles (radians*8192) and the clamped throttle.
//  - Config port: cfg_we_i writes register cfg_addr_i (0 wheelbase,
//    1 track width, 2 steer limit, 3 throttle limit). Write only when idle.
//  - Throughput: one request per cycle while the output does not stall. The
//    pipe is the rotation CORDIC (sin/cos) followed by two vectoring CORDICs
//    (atan), one stage each per iteration, plus degree conversion,
//    multiply, sum, setup and output stages.
//  - Stall: the whole pipe holds while the output register is full and
//    m_axis_tready is low; nothing is dropped or repeated. Bubbles are not
//    squeezed out while the pipe holds.
//  - Reset: all valid bits clear, registers return to their defaults
//    (0.75 m, 0.55 m, pi/3, throttle 50.0). No clearing pass.
//  - Link down: every output field of that request is zero.
// ---------------------------------------------------------------------------
module ackermann_wheel_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] steer_cmd, [31:16] throttle_cmd
  input  logic        s_axis_tuser,  // [0] link_up
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] right_wheel_angle, [29:15] left_wheel_angle, [44:30] center_angle,
  // [60:45] throttle_out, [63:61] zero
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import ackwa_pkg::*;

  localparam int N   = CORDIC_STAGES;
  localparam int TOT = 2 * N + 6;
  localparam int RW  = 24;  // rotation x/y
  localparam int ZW  = 27;  // angles in Q24
  localparam int PW  = 42;  // products
  localparam int VW  = 44;  // vectoring x/y

  // ---------------- configuration registers ----------------
  logic [15:0] wheelbase_q, track_q;
  logic [13:0] steer_lim_q;
  logic [14:0] throt_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q <= 16'd3072;
      track_q     <= 16'd2253;
      steer_lim_q <= 14'd8579;
      throt_lim_q <= 15'd12800;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_WHEELBASE:   wheelbase_q <= cfg_wdata_i;
        REG_TRACK_WIDTH: track_q     <= cfg_wdata_i;
        REG_STEER_LIMIT: steer_lim_q <= cfg_wdata_i[13:0];
        REG_THROT_LIMIT: throt_lim_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // effective limit saturates at pi/2
  logic [13:0] lim;
  assign lim = (steer_lim_q > HALF_PI_Q13) ? HALF_PI_Q13 : steer_lim_q;
  logic signed [15:0] lim_s;
  assign lim_s = $signed({2'b00, lim});

  // ---------------- pipeline control ----------------
  logic [TOT-1:0] v_q;
  logic           adv;
  assign adv           = !v_q[TOT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[TOT-2:0], s_axis_tvalid};
    end
  end

  side_t sb_q [TOT-1];

  // ---------------- stage 0: degree product, throttle clamp ----------------
  logic signed [15:0] s_in, t_in;
  logic        [16:0] mag;
  logic signed [16:0] tl_s;
  logic        [32:0] prod_q;
  logic               neg_q;
  side_t              sb0_d;

  assign s_in = $signed(s_axis_tdata[15:0]);
  assign t_in = $signed(s_axis_tdata[31:16]);
  assign mag  = s_in[15] ? 17'(-{s_in[15], s_in}) : {1'b0, s_in};
  assign tl_s = $signed({2'b00, throt_lim_q});

  always_comb begin
    sb0_d      = '0;
    sb0_d.link = s_axis_tuser;
    if (17'(t_in) > tl_s)          sb0_d.thr = tl_s[15:0];
    else if (17'(t_in) < -tl_s)    sb0_d.thr = 16'(-tl_s);
    else                           sb0_d.thr = t_in;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= 33'(mag) * 33'(DEG_TO_RAD_Q16);
      neg_q    <= s_in[15];
      sb_q[0]  <= sb0_d;
    end
  end

  // ---------------- stage 1: round, clamp, CORDIC start ----------------
  logic signed [RW-1:0] rx_q [N+1];
  logic signed [RW-1:0] ry_q [N+1];
  logic signed [ZW-1:0] rz_q [N+1];
  logic        [16:0]   rnd;
  logic        [13:0]   amag;
  logic signed [14:0]   ang;
  side_t                sb1_d;

  assign rnd  = 17'((prod_q + 33'd32768) >> 16);
  assign amag = (rnd > 17'(lim)) ? lim : rnd[13:0];
  assign ang  = neg_q ? -$signed({1'b0, amag}) : $signed({1'b0, amag});

  always_comb begin
    sb1_d     = sb_q[0];
    sb1_d.ang = ang;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q[0]     <= RW'(CORDIC_ONE) <<< 16;
      ry_q[0]     <= '0;
      rz_q[0]     <= ZW'(ang) <<< 11;
      sb_q[1]     <= sb1_d;
    end
  end

  // ---------------- rotation CORDIC: sin and cos ----------------
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rz_q[i] >= 0) begin
          rx_q[i+1] <= rx_q[i] - (ry_q[i] >>> i);
          ry_q[i+1] <= ry_q[i] + (rx_q[i] >>> i);
          rz_q[i+1] <= rz_q[i] - $signed({3'b000, ATAN_Q24[i]});
        end else begin
          rx_q[i+1] <= rx_q[i] + (ry_q[i] >>> i);
          ry_q[i+1] <= ry_q[i] - (rx_q[i] >>> i);
          rz_q[i+1] <= rz_q[i] + $signed({3'b000, ATAN_Q24[i]});
        end
      end
    end
  end

  // ---------------- multiply: 2L sin, 2L cos, W sin ----------------
  logic signed [PW-1:0] pn_q, pc_q, pw_q;
  logic signed [17:0]   two_l, w_s;
  assign two_l = $signed({1'b0, wheelbase_q, 1'b0});
  assign w_s   = $signed({2'b00, track_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pn_q <= PW'(two_l * ry_q[N]);
      pc_q <= PW'(two_l * rx_q[N]);
      pw_q <= PW'(w_s * ry_q[N]);
    end
  end

  // ---------------- denominators ----------------
  logic signed [PW:0] num_q, dr_q, dl_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= (PW+1)'(pn_q);
      dr_q  <= (PW+1)'(pc_q) - (PW+1)'(pw_q);
      dl_q  <= (PW+1)'(pc_q) + (PW+1)'(pw_q);
    end
  end

  // ---------------- vectoring CORDICs: atan, right [0] and left [1] ----------
  logic signed [VW-1:0] vx_q [2][N+1];
  logic signed [VW-1:0] vy_q [2][N+1];
  logic signed [ZW-1:0] vz_q [2][N+1];
  flg_t                 fl_d [2];

  for (genvar j = 0; j < 2; j++) begin : g_side
    logic signed [PW:0] den;
    assign den = (j == 0) ? dr_q : dl_q;
    assign fl_d[j] = '{zero_num: (num_q == 0), zero_den: (den == 0), num_pos: (num_q > 0)};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        vx_q[j][0] <= den[PW] ? -VW'(den) : VW'(den);
        vy_q[j][0] <= den[PW] ? -VW'(num_q) : VW'(num_q);
        vz_q[j][0] <= '0;
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (vy_q[j][i] >= 0) begin
            vx_q[j][i+1] <= vx_q[j][i] + (vy_q[j][i] >>> i);
            vy_q[j][i+1] <= vy_q[j][i] - (vx_q[j][i] >>> i);
            vz_q[j][i+1] <= vz_q[j][i] + $signed({3'b000, ATAN_Q24[i]});
          end else begin
            vx_q[j][i+1] <= vx_q[j][i] - (vy_q[j][i] >>> i);
            vy_q[j][i+1] <= vy_q[j][i] + (vx_q[j][i] >>> i);
            vz_q[j][i+1] <= vz_q[j][i] - $signed({3'b000, ATAN_Q24[i]});
          end
        end
      end
    end
  end

  // sideband copies; flags join at the vectoring setup stage
  for (genvar k = 2; k < TOT - 1; k++) begin : g_sb
    side_t sb_d;
    always_comb begin
      sb_d = sb_q[k-1];
      if (k == N + 4) begin
        sb_d.fr = fl_d[0];
        sb_d.fl = fl_d[1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sb_q[k] <= sb_d;
      end
    end
  end

  // ---------------- output stage ----------------
  function automatic logic signed [14:0] wheel_fin(input logic signed [ZW-1:0] z,
                                                   input flg_t f,
                                                   input logic signed [15:0] l);
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   q;
    zr = (z + ZW'(1024)) >>> 11;
    q  = zr[15:0];
    if (f.zero_num)      q = '0;
    else if (f.zero_den) q = f.num_pos ? l : -l;
    else if (q > l)      q = l;
    else if (q < -l)     q = -l;
    return q[14:0];
  endfunction

  logic signed [14:0] right_q, left_q, center_q;
  logic signed [15:0] thr_q;
  side_t              sl;
  assign sl = sb_q[TOT-2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sl.link) begin
        right_q  <= wheel_fin(vz_q[0][N], sl.fr, lim_s);
        left_q   <= wheel_fin(vz_q[1][N], sl.fl, lim_s);
        center_q <= sl.ang;
        thr_q    <= sl.thr;
      end else begin
        right_q  <= '0;
        left_q   <= '0;
        center_q <= '0;
        thr_q    <= '0;
      end
    end
  end

  assign m_axis_tdata = {3'b000, thr_q, center_q, left_q, right_q};

  // ---------------- assertions ----------------
  a_right_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (16'(right_q) <= lim_s) && (16'(right_q) >= -lim_s))
    else $error("right wheel angle beyond limit");

  a_center_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (16'(center_q) <= lim_s) && (16'(center_q) >= -lim_s))
    else $error("center angle beyond limit");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(v_q))
    else $error("pipeline moved during stall");

endmodule
